/* sv/assert_macros.svh */
// Assertion shorthands used by the top-level RTL file.
// Each macro expects clk_i and rst_ni in the scope of its use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/lhp_pkg.sv */
// Shared widths, codes and constants of the latency histogram block.
// No dependencies; imported by the top level.
package lhp_pkg;

  localparam int unsigned LAT_W      = 32;
  localparam int unsigned PCT_W      = 14;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned VAL_W      = 22;
  localparam int unsigned BW_W       = 10;
  localparam int unsigned DIV_W      = 64;
  localparam int unsigned DEN_W      = 33;
  localparam int unsigned DCNT_W     = 7;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 88;
  localparam int unsigned APB_AW     = 3;
  localparam int unsigned APB_DW     = 32;

  localparam logic [BW_W-1:0]   BW_RESET  = 10'd10;
  localparam logic [PCT_W-1:0]  PCT_FULL  = 14'd10000;
  localparam logic [DCNT_W-1:0] DIV_STEPS = 7'd64;
  localparam logic              REG_BUCKET_WIDTH = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_RECORD = 2'd0,
    CMD_PCT    = 2'd1,
    CMD_AVG    = 2'd2
  } cmd_e;

endpackage

/* sv/lhp_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
module lhp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/latency_histogram_percentile.sv */
// Latency histogram with percentile and average queries, top level.
// Depends on lhp_pkg, lhp_ram and assert_macros.svh.
//
// Usage:
// - Input beats arrive on s_axis; tuser carries the command, tdata the latency and
//   percentile. Record beats give no output; percentile and average queries give one
//   beat on m_axis. Command code 3 is dropped.
// - The block works on one beat at a time; s_axis_tready_o is high only when idle.
// - A record goes through a one-bit-per-cycle divider that finds the bucket, then one
//   read and one write of the bucket RAM; a sample past the last bucket skips all
//   three and is counted as an overflow.
// - A percentile query first scales the target, then scans the bucket RAM, one bucket
//   per cycle, stopping at the hit.
// - An average query does a full RAM scan, then two 64-step divides through the same
//   divider.
// - A query on an empty histogram skips the scan and answers with value zero.
// - After reset the bucket RAM is cleared; no beat is accepted until then. APB writes
//   are taken at any time.
// - The result sits in an output register; while the receiver stalls, records still
//   proceed, and a finished query waits for the register to free up.
`include "assert_macros.svh"

module latency_histogram_percentile #(
  parameter int unsigned NUM_BUCKETS = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [31:0] latency_us, [45:32] pct_hundredths, [47:46] zero
  input  logic [lhp_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // [1:0] cmd
  input  logic [lhp_pkg::CMD_W-1:0]        s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [21:0] value_us, [53:22] sample_total, [85:54] overflow_total, [87:86] zero
  output logic [lhp_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  // [0] is_empty
  output logic [0:0]                       m_axis_tuser_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lhp_pkg::APB_AW-1:0]       paddr,
  input  logic [lhp_pkg::APB_DW-1:0]       pwdata,
  output logic [lhp_pkg::APB_DW-1:0]       prdata,
  output logic                             pready
);

  import lhp_pkg::*;

  localparam int unsigned IDX_W  = $clog2(NUM_BUCKETS);
  localparam int unsigned LIM_W  = IDX_W + 1 + BW_W;
  localparam int unsigned RUN_W  = CNT_W + IDX_W + PCT_W;
  localparam int unsigned PROD_W = CNT_W + IDX_W + 1;
  localparam int unsigned EW_W   = IDX_W + 1 + BW_W;
  localparam int unsigned PP_W   = CNT_W + PCT_W;
  localparam int unsigned RW_W   = DEN_W + BW_W;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RCHK  = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_RRD   = 4'd4;
  localparam logic [3:0] S_RWR   = 4'd5;
  localparam logic [3:0] S_PMUL  = 4'd6;
  localparam logic [3:0] S_PSCAN = 4'd7;
  localparam logic [3:0] S_PFIN  = 4'd8;
  localparam logic [3:0] S_ASCAN = 4'd9;
  localparam logic [3:0] S_ADIV2 = 4'd10;
  localparam logic [3:0] S_AFIN  = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  // control registers
  logic [3:0]       state_q, state_d;
  logic [BW_W-1:0]  width_q, width_d;
  logic [CNT_W-1:0] smp_q, smp_d;
  logic [CNT_W-1:0] ovf_q, ovf_d;
  logic [IDX_W-1:0] clr_q, clr_d;
  logic [IDX_W:0]   scan_q, scan_d;
  logic             rd_vld_q, rd_vld_d;
  logic             prod_vld_q, prod_vld_d;
  logic             m_vld_q, m_vld_d;

  // payload registers
  cmd_e              cmd_q, cmd_d;
  logic [LAT_W-1:0]  lat_q, lat_d;
  logic [PCT_W-1:0]  pct_q, pct_d;
  logic [DEN_W-1:0]  div_rem_q, div_rem_d;
  logic [DIV_W-1:0]  div_quo_q, div_quo_d;
  logic [DEN_W-1:0]  div_den_q, div_den_d;
  logic [DCNT_W-1:0] div_cnt_q, div_cnt_d;
  logic [3:0]        div_ret_q, div_ret_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic              prod_last_q, prod_last_d;
  logic [RUN_W-1:0]  run_q, run_d;
  logic [DIV_W-1:0]  acc_q, acc_d;
  logic [IDX_W:0]    edge_q, edge_d;
  logic [VAL_W-1:0]  q1_lo_q, q1_lo_d;
  logic [VAL_W-1:0]  res_val_q, res_val_d;
  logic [VAL_W-1:0]  out_val_q, out_val_d;
  logic [CNT_W-1:0]  out_smp_q, out_smp_d;
  logic [CNT_W-1:0]  out_ovf_q, out_ovf_d;
  logic              out_empty_q, out_empty_d;

  // RAM port
  logic             mem_en, mem_we;
  logic [IDX_W-1:0] mem_addr;
  logic [CNT_W-1:0] mem_wdata, mem_rdata;

  logic [BW_W-1:0]  w_eff;
  logic             cfg_we;
  logic             in_acc;
  logic [DEN_W:0]   div_t;
  logic [DEN_W:0]   div_sub;
  logic             div_ge;

  lhp_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_BUCKETS)
  ) u_bucket_ram (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign w_eff  = (width_q == '0) ? BW_W'(1) : width_q;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_BUCKET_WIDTH);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BUCKET_WIDTH) ? APB_DW'(width_q) : '0;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign div_t   = {div_rem_q, div_quo_q[DIV_W-1]};
  assign div_sub = div_t - {1'b0, div_den_q};
  assign div_ge  = (div_t >= {1'b0, div_den_q});

  always_comb begin
    logic [LIM_W-1:0]  lim;
    logic [PCT_W-1:0]  pct_sat;
    logic [PP_W-1:0]   pprod;
    logic [PP_W-1:0]   thr;
    logic [RUN_W-1:0]  run_n;
    logic [DIV_W-1:0]  acc_n;
    logic [EW_W-1:0]   edge_prod;
    logic [RW_W-1:0]   rem_w;
    logic [CNT_W-1:0]  avg_mul;
    logic              issue;
    logic              last;

    lim       = LIM_W'(NUM_BUCKETS) * LIM_W'(w_eff);
    pct_sat   = (pct_q > PCT_FULL) ? PCT_FULL : pct_q;
    pprod     = PP_W'(smp_q) * PP_W'(pct_sat);
    thr       = (pprod > (PP_W'(PCT_FULL) - PP_W'(1))) ?
                (pprod - (PP_W'(PCT_FULL) - PP_W'(1))) : '0;
    run_n     = run_q + RUN_W'(PP_W'(mem_rdata) * PP_W'(PCT_FULL));
    acc_n     = acc_q + DIV_W'(prod_q);
    edge_prod = EW_W'(edge_q) * EW_W'(w_eff);
    rem_w     = RW_W'(div_rem_q) * RW_W'(w_eff);
    avg_mul   = CNT_W'(q1_lo_q) * CNT_W'(w_eff);
    issue     = (scan_q < (IDX_W + 1)'(NUM_BUCKETS));
    last      = (rd_idx_q == IDX_W'(NUM_BUCKETS - 1));

    state_d     = state_q;
    width_d     = cfg_we ? pwdata[BW_W-1:0] : width_q;
    smp_d       = smp_q;
    ovf_d       = ovf_q;
    clr_d       = clr_q;
    scan_d      = scan_q;
    rd_vld_d    = 1'b0;
    prod_vld_d  = 1'b0;
    m_vld_d     = m_vld_q && !m_axis_tready_i;
    cmd_d       = cmd_q;
    lat_d       = lat_q;
    pct_d       = pct_q;
    div_rem_d   = div_rem_q;
    div_quo_d   = div_quo_q;
    div_den_d   = div_den_q;
    div_cnt_d   = div_cnt_q;
    div_ret_d   = div_ret_q;
    idx_d       = idx_q;
    rd_idx_d    = scan_q[IDX_W-1:0];
    prod_d      = PROD_W'(mem_rdata) * PROD_W'({rd_idx_q, 1'b1});
    prod_last_d = rd_vld_q && last;
    run_d       = run_q;
    acc_d       = acc_q;
    edge_d      = edge_q;
    q1_lo_d     = q1_lo_q;
    res_val_d   = res_val_q;
    out_val_d   = out_val_q;
    out_smp_d   = out_smp_q;
    out_ovf_d   = out_ovf_q;
    out_empty_d = out_empty_q;
    mem_en      = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = scan_q[IDX_W-1:0];
    mem_wdata   = mem_rdata + CNT_W'(1);

    case (state_q)
      S_CLR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(NUM_BUCKETS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        scan_d = '0;
        run_d  = '0;
        acc_d  = '0;
        if (in_acc) begin
          cmd_d = cmd_e'(s_axis_tuser_i);
          lat_d = s_axis_tdata_i[LAT_W-1:0];
          pct_d = s_axis_tdata_i[LAT_W +: PCT_W];
          case (cmd_e'(s_axis_tuser_i))
            CMD_RECORD: state_d = S_RCHK;
            CMD_PCT: begin
              if (smp_q == '0) begin
                res_val_d = '0;
                state_d   = S_OUT;
              end else begin
                state_d = S_PMUL;
              end
            end
            CMD_AVG: begin
              if (smp_q == '0) begin
                res_val_d = '0;
                state_d   = S_OUT;
              end else begin
                state_d = S_ASCAN;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_RCHK: begin
        if (lat_q >= LAT_W'(lim)) begin
          ovf_d   = ovf_q + CNT_W'(1);
          smp_d   = smp_q + CNT_W'(1);
          state_d = S_IDLE;
        end else begin
          // quotient fits in IDX_W bits, so start with the upper bits preloaded
          div_rem_d = DEN_W'(lat_q >> IDX_W);
          div_quo_d = DIV_W'(lat_q) << (DIV_W - IDX_W);
          div_den_d = DEN_W'(w_eff);
          div_cnt_d = DCNT_W'(IDX_W);
          div_ret_d = S_RRD;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        div_rem_d = div_ge ? div_sub[DEN_W-1:0] : div_t[DEN_W-1:0];
        div_quo_d = {div_quo_q[DIV_W-2:0], div_ge};
        div_cnt_d = div_cnt_q - DCNT_W'(1);
        if (div_cnt_q == DCNT_W'(1)) begin
          state_d = div_ret_q;
        end
      end
      S_RRD: begin
        mem_en   = 1'b1;
        mem_addr = div_quo_q[IDX_W-1:0];
        idx_d    = div_quo_q[IDX_W-1:0];
        state_d  = S_RWR;
      end
      S_RWR: begin
        mem_en   = 1'b1;
        mem_we   = 1'b1;
        mem_addr = idx_q;
        smp_d    = smp_q + CNT_W'(1);
        state_d  = S_IDLE;
      end
      S_PMUL: begin
        div_quo_d = DIV_W'(thr);
        state_d   = S_PSCAN;
      end
      S_PSCAN: begin
        // compare the scaled running sum against the threshold held in the quotient
        mem_en   = issue;
        rd_vld_d = issue;
        scan_d   = issue ? scan_q + (IDX_W + 1)'(1) : scan_q;
        if (rd_vld_q) begin
          run_d = run_n;
          if (run_n >= RUN_W'(div_quo_q[PP_W-1:0])) begin
            edge_d  = (IDX_W + 1)'(rd_idx_q) + (IDX_W + 1)'(1);
            state_d = S_PFIN;
          end else if (last) begin
            edge_d  = (IDX_W + 1)'(NUM_BUCKETS);
            state_d = S_PFIN;
          end
        end
      end
      S_PFIN: begin
        res_val_d = VAL_W'(edge_prod);
        state_d   = S_OUT;
      end
      S_ASCAN: begin
        mem_en     = issue;
        rd_vld_d   = issue;
        scan_d     = issue ? scan_q + (IDX_W + 1)'(1) : scan_q;
        prod_vld_d = rd_vld_q;
        if (prod_vld_q) begin
          acc_d = acc_n;
          if (prod_last_q) begin
            div_rem_d = '0;
            div_quo_d = acc_n;
            div_den_d = {smp_q, 1'b0};
            div_cnt_d = DIV_STEPS;
            div_ret_d = S_ADIV2;
            state_d   = S_DIV;
          end
        end
      end
      S_ADIV2: begin
        q1_lo_d   = div_quo_q[VAL_W-1:0];
        div_rem_d = '0;
        div_quo_d = DIV_W'(rem_w);
        div_cnt_d = DIV_STEPS;
        div_ret_d = S_AFIN;
        state_d   = S_DIV;
      end
      S_AFIN: begin
        res_val_d = avg_mul[VAL_W-1:0] + div_quo_q[VAL_W-1:0];
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (!m_vld_q || m_axis_tready_i) begin
          m_vld_d     = 1'b1;
          out_val_d   = res_val_q;
          out_smp_d   = smp_q;
          out_ovf_d   = ovf_q;
          out_empty_d = (smp_q == '0);
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      width_q    <= BW_RESET;
      smp_q      <= '0;
      ovf_q      <= '0;
      clr_q      <= '0;
      scan_q     <= '0;
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
      m_vld_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      width_q    <= width_d;
      smp_q      <= smp_d;
      ovf_q      <= ovf_d;
      clr_q      <= clr_d;
      scan_q     <= scan_d;
      rd_vld_q   <= rd_vld_d;
      prod_vld_q <= prod_vld_d;
      m_vld_q    <= m_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    lat_q       <= lat_d;
    pct_q       <= pct_d;
    div_rem_q   <= div_rem_d;
    div_quo_q   <= div_quo_d;
    div_den_q   <= div_den_d;
    div_cnt_q   <= div_cnt_d;
    div_ret_q   <= div_ret_d;
    idx_q       <= idx_d;
    rd_idx_q    <= rd_idx_d;
    prod_q      <= prod_d;
    prod_last_q <= prod_last_d;
    run_q       <= run_d;
    acc_q       <= acc_d;
    edge_q      <= edge_d;
    q1_lo_q     <= q1_lo_d;
    res_val_q   <= res_val_d;
    out_val_q   <= out_val_d;
    out_smp_q   <= out_smp_d;
    out_ovf_q   <= out_ovf_d;
    out_empty_q <= out_empty_d;
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = {2'b00, out_ovf_q, out_smp_q, out_val_q};
  assign m_axis_tuser_o  = out_empty_q;

  `ASSERT_IMPLIES(a_ram_write_phase, mem_we, (state_q == S_CLR) || (state_q == S_RWR),
    "bucket RAM written outside clear or record write")
  `ASSERT_NEXT(a_record_counts, state_q == S_RWR, smp_q == $past(smp_q) + CNT_W'(1),
    "record write did not advance the sample count")
  `ASSERT_IMPLIES(a_div_steps_left, state_q == S_DIV, div_cnt_q != '0,
    "divider running with no steps left")

endmodule
